@@ rtl/tsh_pkg.sv @@
// ----------------------------------------------------------------------------
// tsh_pkg
// shared types and constants of the touch sensor hysteresis filter
// ----------------------------------------------------------------------------
package tsh_pkg;

	localparam int IDX_W      = 4;
	localparam int SAMPLE_W   = 10;
	localparam int FRAC_W     = 8;
	localparam int LEVEL_W    = SAMPLE_W + FRAC_W;
	localparam int DIVISOR_W  = 10;
	localparam int PROD_W     = LEVEL_W + DIVISOR_W;
	localparam int DIVIDEND_W = PROD_W + 1;
	localparam int DIV_STEPS  = LEVEL_W / 2;
	localparam int DIV_CNT_W  = $clog2(DIV_STEPS);
	localparam int PCT_W      = 7;
	localparam int PCT_SCALE  = 100;
	localparam int PCT_MAX    = 100;
	localparam int THR_MIN    = 1;
	localparam int P1_W       = SAMPLE_W + PCT_W;
	localparam int GAIN_W     = 16;
	localparam int P2_W       = P1_W + GAIN_W;
	localparam int GAIN_SHIFT = SAMPLE_W + 8;
	localparam int MASK_W     = 16;
	localparam int ENTRY_W    = LEVEL_W + 2;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 16;

	localparam logic [DIVISOR_W-1:0] RST_AVG     = 10'd200;
	localparam logic [PCT_W-1:0]     RST_TOUCH   = 7'd95;
	localparam logic [PCT_W-1:0]     RST_RELEASE = 7'd65;
	localparam logic [GAIN_W-1:0]    RST_GAIN    = 16'd256;

	typedef enum logic [1:0] {
		CHG_NONE    = 2'd0,
		CHG_TOUCH   = 2'd1,
		CHG_RELEASE = 2'd2
	} chg_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_AVG     = 3'd0,
		CFG_TOUCH   = 3'd1,
		CFG_RELEASE = 3'd2,
		CFG_GAIN    = 3'd3,
		CFG_TOGGLE  = 3'd4,
		CFG_IGNORE  = 3'd5
	} cfg_reg_t;

	typedef struct packed {
		logic [IDX_W-1:0]    sensor_index;
		logic [SAMPLE_W-1:0] raw_sample;
	} in_word_t;

	typedef struct packed {
		logic [IDX_W-1:0] result_sensor;
		logic             touch_state;
		logic [1:0]       change_code;
		logic [PCT_W-1:0] proximity_percent;
	} out_word_t;

	typedef struct packed {
		logic [DIVISOR_W-1:0] averaging_strength;
		logic [PCT_W-1:0]     touch_threshold;
		logic [PCT_W-1:0]     release_threshold;
		logic [GAIN_W-1:0]    proximity_gain;
		logic                 toggle_mode;
		logic [MASK_W-1:0]    ignore_mask;
	} cfg_t;

	typedef struct packed {
		logic load;
		logic mul;
		logic add;
		logic div;
		logic pct1;
		logic pct2;
		logic commit;
	} cmd_t;

endpackage

@@ rtl/tsh_ram.sv @@
// ----------------------------------------------------------------------------
// tsh_ram
// generic single write port, single read port ram with registered read
// ----------------------------------------------------------------------------
module tsh_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                                     clk,
	input  logic                                     we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                         wdata,
	input  logic                                     re,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

@@ rtl/tsh_ctrl.sv @@
// ----------------------------------------------------------------------------
// tsh_ctrl
// sequencer: read, multiply, divide, scale, decide and write back per word
// ----------------------------------------------------------------------------
module tsh_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_stall,
	output logic          out_valid,
	input  logic          out_stall,
	output tsh_pkg::cmd_t cmd
);

	typedef enum logic [2:0] {
		S_IDLE,
		S_MUL,
		S_ADD,
		S_DIV,
		S_PCT1,
		S_PCT2,
		S_OUT
	} state_t;

	state_t                         state_q;
	logic [tsh_pkg::DIV_CNT_W-1:0]  cnt_q;
	logic                           out_valid_q;
	logic                           commit;

	assign in_stall  = (state_q != S_IDLE);
	assign out_valid = out_valid_q;
	assign commit    = (state_q == S_OUT) && (!out_valid_q || !out_stall);

	always_comb begin
		cmd        = '0;
		cmd.load   = in_valid && (state_q == S_IDLE);
		cmd.mul    = (state_q == S_MUL);
		cmd.add    = (state_q == S_ADD);
		cmd.div    = (state_q == S_DIV);
		cmd.pct1   = (state_q == S_PCT1);
		cmd.pct2   = (state_q == S_PCT2);
		cmd.commit = commit;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (commit) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						state_q <= S_MUL;
					end
				end
				S_MUL: begin
					state_q <= S_ADD;
				end
				S_ADD: begin
					state_q <= S_DIV;
					cnt_q   <= '0;
				end
				S_DIV: begin
					if (cnt_q == tsh_pkg::DIV_CNT_W'(tsh_pkg::DIV_STEPS - 1)) begin
						state_q <= S_PCT1;
					end else begin
						cnt_q <= cnt_q + 1'b1;
					end
				end
				S_PCT1: begin
					state_q <= S_PCT2;
				end
				S_PCT2: begin
					state_q <= S_OUT;
				end
				S_OUT: begin
					if (commit) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// a result is never loaded over one still waiting
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.commit |-> !(out_valid_q && out_stall))
		else $error("result loaded over a stalled word");

	a_commit_shows: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.commit |=> out_valid)
		else $error("committed result not shown");

	a_accept_starts: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> (state_q == S_MUL))
		else $error("accepted word did not start");

	a_div_count: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DIV) |-> (cnt_q < tsh_pkg::DIV_CNT_W'(tsh_pkg::DIV_STEPS)))
		else $error("divider step count out of range");

endmodule

@@ rtl/tsh_dp.sv @@
// ----------------------------------------------------------------------------
// tsh_dp
// datapath: per-sensor store, filter multiply and divide, percent scaling,
// hysteresis decision and output register
// ----------------------------------------------------------------------------
module tsh_dp #(
	parameter int SENSOR_COUNT = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  tsh_pkg::cfg_t      cfg,
	input  tsh_pkg::cmd_t      cmd,
	input  tsh_pkg::in_word_t  in_data,
	output tsh_pkg::out_word_t out_data
);

	localparam int AW = (SENSOR_COUNT > 1) ? $clog2(SENSOR_COUNT) : 1;

	logic [tsh_pkg::IDX_W-1:0]      idx_in;
	logic [tsh_pkg::IDX_W-1:0]      idx_q;
	logic [AW-1:0]                  addr_q;
	logic [tsh_pkg::SAMPLE_W-1:0]   sample_q;
	logic [SENSOR_COUNT-1:0]        valid_q;
	logic [tsh_pkg::ENTRY_W-1:0]    rd_entry;
	logic [tsh_pkg::ENTRY_W-1:0]    wr_entry;
	logic [tsh_pkg::LEVEL_W-1:0]    f_cur;
	logic [tsh_pkg::LEVEL_W-1:0]    f_q;
	logic                           act_q;
	logic                           tog_q;
	logic [tsh_pkg::PROD_W-1:0]     prod_q;
	logic [tsh_pkg::DIVIDEND_W-1:0] dividend;
	logic [tsh_pkg::DIVISOR_W-1:0]  rem_q;
	logic [tsh_pkg::LEVEL_W-1:0]    dq_q;
	logic [tsh_pkg::DIVISOR_W-1:0]  rem_nxt;
	logic [tsh_pkg::LEVEL_W-1:0]    dq_nxt;
	logic [tsh_pkg::SAMPLE_W-1:0]   level;
	logic [tsh_pkg::P1_W-1:0]       p1_q;
	logic [tsh_pkg::P2_W-1:0]       p2;
	logic [tsh_pkg::P2_W-tsh_pkg::GAIN_SHIFT-1:0] pct_raw;
	logic [tsh_pkg::PCT_W-1:0]      pct_q;
	logic                           ignored;
	logic                           update;
	logic [tsh_pkg::PCT_W-1:0]      thr_t;
	logic [tsh_pkg::PCT_W-1:0]      thr_r;
	logic                           status;
	logic                           tog;
	logic                           report;
	tsh_pkg::chg_t                  change;
	tsh_pkg::out_word_t             out_q;

	// clamp sensor number to the last sensor
	assign idx_in = (32'(in_data.sensor_index) >= SENSOR_COUNT)
		? tsh_pkg::IDX_W'(SENSOR_COUNT - 1) : in_data.sensor_index;

	assign ignored = cfg.ignore_mask[idx_q];
	assign update  = !ignored && (cfg.averaging_strength != '0);

	tsh_ram #(
		.WIDTH (tsh_pkg::ENTRY_W),
		.DEPTH (SENSOR_COUNT)
	) u_store (
		.clk   (clk),
		.we    (cmd.commit),
		.waddr (addr_q),
		.wdata (wr_entry),
		.re    (cmd.load),
		.raddr (AW'(idx_in)),
		.rdata (rd_entry)
	);

	// never written entries read as reset value
	assign f_cur = valid_q[addr_q] ? rd_entry[tsh_pkg::LEVEL_W-1:0] : '0;

	assign dividend = {1'b0, prod_q}
		+ tsh_pkg::DIVIDEND_W'({sample_q, {tsh_pkg::FRAC_W{1'b0}}});

	// two restoring division steps per cycle
	always_comb begin
		logic [tsh_pkg::DIVISOR_W:0]   r2;
		logic [tsh_pkg::DIVISOR_W-1:0] r;
		logic [tsh_pkg::LEVEL_W-1:0]   d;
		r = rem_q;
		d = dq_q;
		for (int i = 0; i < 2; i++) begin
			r2 = {r, d[tsh_pkg::LEVEL_W-1]};
			d  = {d[tsh_pkg::LEVEL_W-2:0], 1'b0};
			if (r2 >= {1'b0, cfg.averaging_strength}) begin
				r2   = r2 - {1'b0, cfg.averaging_strength};
				d[0] = 1'b1;
			end
			r = r2[tsh_pkg::DIVISOR_W-1:0];
		end
		rem_nxt = r;
		dq_nxt  = d;
	end

	assign level = (cfg.averaging_strength == '0) ? sample_q
		: dq_q[tsh_pkg::LEVEL_W-1:tsh_pkg::FRAC_W];

	assign p2      = tsh_pkg::P2_W'(p1_q) * tsh_pkg::P2_W'(cfg.proximity_gain);
	assign pct_raw = p2[tsh_pkg::P2_W-1:tsh_pkg::GAIN_SHIFT];

	// thresholds and hysteresis
	always_comb begin
		if (cfg.touch_threshold < tsh_pkg::PCT_W'(tsh_pkg::THR_MIN)) begin
			thr_t = tsh_pkg::PCT_W'(tsh_pkg::THR_MIN);
		end else if (cfg.touch_threshold > tsh_pkg::PCT_W'(tsh_pkg::PCT_MAX)) begin
			thr_t = tsh_pkg::PCT_W'(tsh_pkg::PCT_MAX);
		end else begin
			thr_t = cfg.touch_threshold;
		end
		thr_r = (cfg.release_threshold >= thr_t) ? thr_t - 1'b1 : cfg.release_threshold;

		status = act_q;
		change = tsh_pkg::CHG_NONE;
		if (pct_q >= thr_t) begin
			if (!act_q) begin
				change = tsh_pkg::CHG_TOUCH;
			end
			status = 1'b1;
		end else if (pct_q < thr_r) begin
			if (act_q) begin
				change = tsh_pkg::CHG_RELEASE;
			end
			status = 1'b0;
		end

		tog    = tog_q;
		report = status;
		if (cfg.toggle_mode) begin
			if (change == tsh_pkg::CHG_RELEASE) begin
				change = tsh_pkg::CHG_NONE;
			end else if (change == tsh_pkg::CHG_TOUCH) begin
				if (tog_q) begin
					tog    = 1'b0;
					change = tsh_pkg::CHG_RELEASE;
				end else begin
					tog = 1'b1;
				end
			end
			report = tog;
		end
	end

	assign wr_entry = {tog, status, update ? dq_q : f_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (cmd.commit) begin
			valid_q[addr_q] <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			idx_q    <= idx_in;
			addr_q   <= AW'(idx_in);
			sample_q <= in_data.raw_sample;
		end
		if (cmd.mul) begin
			f_q    <= f_cur;
			act_q  <= valid_q[addr_q] & rd_entry[tsh_pkg::LEVEL_W];
			tog_q  <= valid_q[addr_q] & rd_entry[tsh_pkg::LEVEL_W+1];
			prod_q <= tsh_pkg::PROD_W'(f_cur)
				* tsh_pkg::PROD_W'(cfg.averaging_strength - 1'b1);
		end
		if (cmd.add) begin
			rem_q <= dividend[tsh_pkg::DIVIDEND_W-2:tsh_pkg::LEVEL_W];
			dq_q  <= dividend[tsh_pkg::LEVEL_W-1:0];
		end
		if (cmd.div) begin
			rem_q <= rem_nxt;
			dq_q  <= dq_nxt;
		end
		if (cmd.pct1) begin
			p1_q <= tsh_pkg::P1_W'(level) * tsh_pkg::P1_W'(tsh_pkg::PCT_SCALE);
		end
		if (cmd.pct2) begin
			if (ignored) begin
				pct_q <= '0;
			end else if (pct_raw > (tsh_pkg::P2_W - tsh_pkg::GAIN_SHIFT)'(tsh_pkg::PCT_MAX)) begin
				pct_q <= tsh_pkg::PCT_W'(tsh_pkg::PCT_MAX);
			end else begin
				pct_q <= pct_raw[tsh_pkg::PCT_W-1:0];
			end
		end
		if (cmd.commit) begin
			out_q.result_sensor     <= idx_q;
			out_q.touch_state       <= report;
			out_q.change_code       <= change;
			out_q.proximity_percent <= pct_q;
		end
	end

	assign out_data = out_q;

endmodule

@@ rtl/touch_sensor_hysteresis_filter_top.sv @@
// ----------------------------------------------------------------------------
// touch_sensor_hysteresis_filter_top
// averaging filter, percent scaling and touch/release hysteresis per sensor
// ----------------------------------------------------------------------------
// usage:
//   in channel (in_valid/in_stall/in_data) takes one word per sample: sensor
//   number and raw reading. out channel (out_valid/out_stall/out_data) gives
//   one word per sample: sensor, status, change code and percent.
//   cfg channel (cfg_valid/cfg_ready/cfg_index/cfg_data) writes the six
//   setting registers; cfg_ready is always high, writes belong in idle time.
// sequence:
//   a word is read from the store, then goes through the filter multiply,
//   add, divide, two scaling multiplies, the decision and the write back.
//   the filter divider makes two quotient bits per cycle. a new word is
//   accepted only after the result of the last one is loaded, at the
//   earliest in the cycle after that load.
// reset:
//   settings return to their defaults; all filter levels and statuses read
//   as zero until a sensor is first written back.
// stall:
//   a result waits in the output register; the next word is still accepted
//   and is held at its last step until the output register frees up.
// ----------------------------------------------------------------------------
module touch_sensor_hysteresis_filter_top #(
	parameter int SENSOR_COUNT = 16
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_stall,
	input  tsh_pkg::in_word_t                   in_data,
	output logic                                out_valid,
	input  logic                                out_stall,
	output tsh_pkg::out_word_t                  out_data,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [tsh_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [tsh_pkg::CFG_DATA_W-1:0]      cfg_data
);

	tsh_pkg::cfg_t cfg_q;
	tsh_pkg::cmd_t cmd;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.averaging_strength <= tsh_pkg::RST_AVG;
			cfg_q.touch_threshold    <= tsh_pkg::RST_TOUCH;
			cfg_q.release_threshold  <= tsh_pkg::RST_RELEASE;
			cfg_q.proximity_gain     <= tsh_pkg::RST_GAIN;
			cfg_q.toggle_mode        <= 1'b0;
			cfg_q.ignore_mask        <= '0;
		end else if (cfg_valid && cfg_ready) begin
			case (tsh_pkg::cfg_reg_t'(cfg_index))
				tsh_pkg::CFG_AVG: begin
					cfg_q.averaging_strength <= cfg_data[tsh_pkg::DIVISOR_W-1:0];
				end
				tsh_pkg::CFG_TOUCH: begin
					cfg_q.touch_threshold <= cfg_data[tsh_pkg::PCT_W-1:0];
				end
				tsh_pkg::CFG_RELEASE: begin
					cfg_q.release_threshold <= cfg_data[tsh_pkg::PCT_W-1:0];
				end
				tsh_pkg::CFG_GAIN: begin
					cfg_q.proximity_gain <= cfg_data[tsh_pkg::GAIN_W-1:0];
				end
				tsh_pkg::CFG_TOGGLE: begin
					cfg_q.toggle_mode <= cfg_data[0];
				end
				tsh_pkg::CFG_IGNORE: begin
					cfg_q.ignore_mask <= cfg_data[tsh_pkg::MASK_W-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	tsh_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.cmd       (cmd)
	);

	tsh_dp #(
		.SENSOR_COUNT (SENSOR_COUNT)
	) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg_q),
		.cmd      (cmd),
		.in_data  (in_data),
		.out_data (out_data)
	);

endmodule

@@ bench/tb_touch_sensor_hysteresis_filter_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_touch_sensor_hysteresis_filter_top
// Self-checking bench for the touch sensor hysteresis filter. Each accepted
// sample runs through a local model of the averaging filter, percent scaling
// and touch/release hysteresis. The predicted word is queued and compared
// field by field with each word taken from the output channel. Directed tests
// cover the defaults, threshold clamping, pass-through, ignored sensors,
// toggle mode and a long output hold. Random phases, the first two with fixed
// settings and the rest with random settings, then drive runs of samples on
// one sensor at a time, with bursty input and random output stalls.
// ----------------------------------------------------------------------------
module tb_touch_sensor_hysteresis_filter_top;

	localparam int SENSORS      = 16;
	localparam int CLK_HALF     = 10;
	localparam int RESET_CYCLES = 7;
	localparam int RANDOM_ITEMS = 2000;
	localparam int LONG_HOLD    = 400;
	localparam int DRAIN_CYCLES = 40;
	localparam int TIMEOUT_NS   = 20_000_000;
	localparam int SAMPLE_MAX   = (1 << tsh_pkg::SAMPLE_W) - 1;

	logic                           clk = 1'b0;
	logic                           arst_n = 1'b0;
	logic                           in_valid = 1'b0;
	logic                           in_stall;
	tsh_pkg::in_word_t              in_data = '0;
	logic                           out_valid;
	logic                           out_stall = 1'b0;
	tsh_pkg::out_word_t             out_data;
	logic                           cfg_valid = 1'b0;
	logic                           cfg_ready;
	logic [tsh_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
	logic [tsh_pkg::CFG_DATA_W-1:0] cfg_data = '0;

	logic [tsh_pkg::DIVISOR_W-1:0] avg_strength;
	logic [tsh_pkg::PCT_W-1:0]     touch_thr;
	logic [tsh_pkg::PCT_W-1:0]     release_thr;
	logic [tsh_pkg::GAIN_W-1:0]    prox_gain;
	logic                          toggle_on;
	logic [tsh_pkg::MASK_W-1:0]    ignore_bits;

	logic [tsh_pkg::LEVEL_W-1:0] level_q8 [SENSORS];
	logic                        touched [SENSORS];
	logic                        toggled [SENSORS];

	tsh_pkg::out_word_t pending_results [$];
	int                 mismatches = 0;
	int                 holds_asked = 0;
	int                 burst_left = 0;
	bit                 pacing = 1'b0;

	touch_sensor_hysteresis_filter_top #(
		.SENSOR_COUNT(SENSORS)
	) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.in_data(in_data),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_data(out_data),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	initial begin
		forever #CLK_HALF clk = ~clk;
	end

	initial begin
		#TIMEOUT_NS;
		$display("touch_sensor_hysteresis_filter_top: mismatch");
		$finish;
	end

	function automatic tsh_pkg::out_word_t filter_sample(tsh_pkg::in_word_t w);
		int unsigned               s;
		logic [63:0]               acc;
		logic [63:0]               lvl;
		logic [63:0]               pct;
		logic [tsh_pkg::PCT_W-1:0] thr_on;
		logic [tsh_pkg::PCT_W-1:0] thr_off;
		logic                      status;
		tsh_pkg::chg_t             chg;
		tsh_pkg::out_word_t        res;
		s = w.sensor_index;
		if (s >= SENSORS)
			s = SENSORS - 1;
		if (ignore_bits[s]) begin
			pct = '0;
		end else begin
			if (avg_strength != 0) begin
				acc = (64'(level_q8[s]) * (64'(avg_strength) - 64'd1)
					+ (64'(w.raw_sample) << tsh_pkg::FRAC_W)) / 64'(avg_strength);
				level_q8[s] = acc[tsh_pkg::LEVEL_W-1:0];
				lvl = 64'(acc[tsh_pkg::LEVEL_W-1:tsh_pkg::FRAC_W]);
			end else begin
				lvl = 64'(w.raw_sample);
			end
			pct = (lvl * 64'(tsh_pkg::PCT_SCALE) * 64'(prox_gain)) >> tsh_pkg::GAIN_SHIFT;
			if (pct > 64'(tsh_pkg::PCT_MAX))
				pct = 64'(tsh_pkg::PCT_MAX);
		end
		thr_on = touch_thr;
		if (thr_on < tsh_pkg::PCT_W'(tsh_pkg::THR_MIN))
			thr_on = tsh_pkg::PCT_W'(tsh_pkg::THR_MIN);
		if (thr_on > tsh_pkg::PCT_W'(tsh_pkg::PCT_MAX))
			thr_on = tsh_pkg::PCT_W'(tsh_pkg::PCT_MAX);
		thr_off = release_thr;
		if (thr_off >= thr_on)
			thr_off = thr_on - 1'b1;
		status = touched[s];
		chg = tsh_pkg::CHG_NONE;
		if (pct >= 64'(thr_on)) begin
			if (!status)
				chg = tsh_pkg::CHG_TOUCH;
			status = 1'b1;
		end else if (pct < 64'(thr_off)) begin
			if (status)
				chg = tsh_pkg::CHG_RELEASE;
			status = 1'b0;
		end
		touched[s] = status;
		if (toggle_on) begin
			if (chg == tsh_pkg::CHG_RELEASE) begin
				chg = tsh_pkg::CHG_NONE;
			end else if (chg == tsh_pkg::CHG_TOUCH) begin
				toggled[s] = !toggled[s];
				if (!toggled[s])
					chg = tsh_pkg::CHG_RELEASE;
			end
			status = toggled[s];
		end
		res.result_sensor = s[tsh_pkg::IDX_W-1:0];
		res.touch_state = status;
		res.change_code = chg;
		res.proximity_percent = pct[tsh_pkg::PCT_W-1:0];
		return res;
	endfunction

	function automatic int pick_value(int lo, int hi, int typ_lo, int typ_hi);
		int roll;
		roll = $urandom_range(0, 99);
		if (roll < 15)
			return lo;
		if (roll < 30)
			return hi;
		if (roll < 80)
			return $urandom_range(typ_lo, typ_hi);
		return $urandom_range(lo, hi);
	endfunction

	// result checker and output stall pattern
	initial begin
		int                 stall_pct;
		int                 mode_left;
		int                 hold_left;
		int                 holds_done;
		tsh_pkg::out_word_t want;
		stall_pct = 0;
		mode_left = 0;
		hold_left = 0;
		holds_done = 0;
		forever begin
			@(posedge clk);
			if (out_valid && !out_stall) begin
				if (pending_results.size() == 0) begin
					$error("unexpected word: sensor %0d", out_data.result_sensor);
					mismatches++;
				end else begin
					want = pending_results.pop_front();
					if (out_data.result_sensor !== want.result_sensor) begin
						$error("result_sensor: expected %0d, got %0d",
							want.result_sensor, out_data.result_sensor);
						mismatches++;
					end
					if (out_data.touch_state !== want.touch_state) begin
						$error("touch_state: expected %0d, got %0d",
							want.touch_state, out_data.touch_state);
						mismatches++;
					end
					if (out_data.change_code !== want.change_code) begin
						$error("change_code: expected %0d, got %0d",
							want.change_code, out_data.change_code);
						mismatches++;
					end
					if (out_data.proximity_percent !== want.proximity_percent) begin
						$error("proximity_percent: expected %0d, got %0d",
							want.proximity_percent, out_data.proximity_percent);
						mismatches++;
					end
				end
			end
			if (holds_done != holds_asked) begin
				holds_done = holds_asked;
				hold_left = LONG_HOLD;
			end
			if (mode_left == 0) begin
				case ($urandom_range(0, 3))
					0: stall_pct = 0;
					1: stall_pct = 20;
					2: stall_pct = 50;
					default: stall_pct = 85;
				endcase
				mode_left = $urandom_range(10, 200);
			end
			mode_left--;
			if (hold_left > 0) begin
				hold_left--;
				out_stall <= 1'b1;
			end else begin
				out_stall <= ($urandom_range(0, 99) < stall_pct);
			end
		end
	end

	task automatic pace_sender();
		int gap;
		if (!pacing)
			return;
		if (burst_left > 0) begin
			burst_left--;
			return;
		end
		burst_left = $urandom_range(0, 15);
		gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 30);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic send_sample(int sensor, int sample);
		tsh_pkg::in_word_t w;
		w.sensor_index = sensor[tsh_pkg::IDX_W-1:0];
		w.raw_sample = sample[tsh_pkg::SAMPLE_W-1:0];
		in_valid <= 1'b1;
		in_data <= w;
		do @(posedge clk); while (in_stall);
		pending_results.push_back(filter_sample(w));
		pace_sender();
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(tsh_pkg::cfg_reg_t idx, int val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val[tsh_pkg::CFG_DATA_W-1:0];
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			tsh_pkg::CFG_AVG:     avg_strength = val[tsh_pkg::DIVISOR_W-1:0];
			tsh_pkg::CFG_TOUCH:   touch_thr = val[tsh_pkg::PCT_W-1:0];
			tsh_pkg::CFG_RELEASE: release_thr = val[tsh_pkg::PCT_W-1:0];
			tsh_pkg::CFG_GAIN:    prox_gain = val[tsh_pkg::GAIN_W-1:0];
			tsh_pkg::CFG_TOGGLE:  toggle_on = val[0];
			tsh_pkg::CFG_IGNORE:  ignore_bits = val[tsh_pkg::MASK_W-1:0];
			default: ;
		endcase
	endtask

	task automatic configure(int avg, int touch, int rel, int gain, int tog, int mask);
		write_reg(tsh_pkg::CFG_AVG, avg);
		write_reg(tsh_pkg::CFG_TOUCH, touch);
		write_reg(tsh_pkg::CFG_RELEASE, rel);
		write_reg(tsh_pkg::CFG_GAIN, gain);
		write_reg(tsh_pkg::CFG_TOGGLE, tog);
		write_reg(tsh_pkg::CFG_IGNORE, mask);
		cfg_valid <= 1'b0;
	endtask

	task automatic test_reset_defaults();
		send_sample(0, SAMPLE_MAX);
		send_sample(15, 0);
		send_sample(0, SAMPLE_MAX);
		send_sample(7, 512);
		send_sample(15, SAMPLE_MAX);
		drain();
	endtask

	task automatic test_threshold_limits();
		// touch of zero acts as one, release above touch drops to touch-1
		configure(0, 0, 99, 16'hFFFF, 0, 0);
		send_sample(1, 0);
		send_sample(1, 1);
		send_sample(1, SAMPLE_MAX);
		send_sample(1, 0);
		drain();
		// touch above 100 acts as 100
		configure(0, 127, 0, 16'hFFFF, 0, 0);
		send_sample(2, SAMPLE_MAX);
		send_sample(2, 0);
		drain();
		configure(0, 100, 99, 256, 0, 0);
		send_sample(2, 0);
		send_sample(2, SAMPLE_MAX);
		drain();
	endtask

	task automatic test_ignored_sensor();
		configure(1, 50, 30, 512, 0, 0);
		send_sample(15, SAMPLE_MAX);
		drain();
		configure(1, 50, 30, 512, 0, 16'h8001);
		send_sample(15, SAMPLE_MAX);
		send_sample(0, SAMPLE_MAX);
		send_sample(5, SAMPLE_MAX);
		drain();
	endtask

	task automatic test_toggle_mode();
		configure(0, 50, 30, 256, 1, 0);
		send_sample(3, SAMPLE_MAX);
		send_sample(3, SAMPLE_MAX);
		send_sample(3, 0);
		send_sample(3, SAMPLE_MAX);
		send_sample(3, 600);
		send_sample(3, 0);
		send_sample(3, SAMPLE_MAX);
		drain();
	endtask

	task automatic test_output_hold();
		configure(2, 60, 40, 300, 0, 0);
		pacing = 1'b0;
		holds_asked++;
		for (int i = 0; i < 40; i++)
			send_sample(i % SENSORS, (i % 3 == 0) ? 0 : SAMPLE_MAX);
		drain();
	endtask

	task automatic send_random_run(output int count);
		int sensor;
		int target;
		int spread;
		int runs;
		int v;
		if ($urandom_range(0, 6) == 0) begin
			send_sample($urandom_range(0, SENSORS - 1), $urandom_range(0, SAMPLE_MAX));
			count = 1;
			return;
		end
		sensor = $urandom_range(0, SENSORS - 1);
		case ($urandom_range(0, 2))
			0: target = $urandom_range(0, 80);
			1: target = $urandom_range(900, SAMPLE_MAX);
			default: target = $urandom_range(0, SAMPLE_MAX);
		endcase
		spread = $urandom_range(0, 40);
		runs = $urandom_range(1, 12);
		for (int i = 0; i < runs; i++) begin
			v = $urandom_range(0, 2 * spread);
			v = target + v - spread;
			if (v < 0)
				v = 0;
			if (v > SAMPLE_MAX)
				v = SAMPLE_MAX;
			send_sample(sensor, v);
		end
		count = runs;
	endtask

	task automatic test_random_phases();
		int sent;
		int phase;
		int phase_len;
		int in_phase;
		int run;
		int mask;
		sent = 0;
		phase = 0;
		while (sent < RANDOM_ITEMS) begin
			case ($urandom_range(0, 3))
				0: mask = 0;
				1: mask = 16'hFFFF;
				2: mask = (1 << $urandom_range(0, 15)) | (1 << $urandom_range(0, 15));
				default: mask = $urandom_range(0, 16'hFFFF);
			endcase
			if (phase == 0)
				configure(SAMPLE_MAX, 127, 127, 16'hFFFF, 0, 0);
			else if (phase == 1)
				configure(0, 1, 0, 0, 1, 16'hFFFF);
			else
				configure(pick_value(0, 1023, 1, 16), pick_value(0, 127, 20, 95),
					pick_value(0, 127, 5, 90), pick_value(0, 16'hFFFF, 200, 1500),
					$urandom_range(0, 1), ($urandom_range(0, 1) == 0) ? 0 : mask);
			pacing = ($urandom_range(0, 3) != 0);
			phase_len = (phase < 2) ? 40 : $urandom_range(80, 250);
			in_phase = 0;
			while (in_phase < phase_len && sent < RANDOM_ITEMS) begin
				send_random_run(run);
				in_phase += run;
				sent += run;
			end
			drain();
			phase++;
		end
	endtask

	initial begin
		avg_strength = tsh_pkg::RST_AVG;
		touch_thr = tsh_pkg::RST_TOUCH;
		release_thr = tsh_pkg::RST_RELEASE;
		prox_gain = tsh_pkg::RST_GAIN;
		toggle_on = 1'b0;
		ignore_bits = '0;
		for (int i = 0; i < SENSORS; i++) begin
			level_q8[i] = '0;
			touched[i] = 1'b0;
			toggled[i] = 1'b0;
		end
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_defaults();
		test_threshold_limits();
		test_ignored_sensor();
		test_toggle_mode();
		test_output_hold();
		test_random_phases();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0)
			$display("touch_sensor_hysteresis_filter_top: match");
		else
			$display("touch_sensor_hysteresis_filter_top: mismatch");
		$finish;
	end

endmodule
